// ===== rtl/rbt_pkg.sv =====
`default_nettype none

package rbt_pkg;

    // Default table dimensions.
    localparam int NUM_SOURCES_DEF = 16;
    localparam int NUM_SLOTS_DEF   = 16;

    // Retry counts above this value share the last histogram bin.
    localparam int BIN_LIMIT = 4;
    localparam int HIST_N    = 2 * (BIN_LIMIT + 1);

    localparam logic [11:0] FLIT_MAX       = 12'hFFF;
    localparam logic [4:0]  SLOTS_IN_USE_RST = 5'd16;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED   = 3'd0;
    localparam logic [2:0] ST_REFRESHED  = 3'd1;
    localparam logic [2:0] ST_FREED      = 3'd2;
    localparam logic [2:0] ST_FREE_MISS  = 3'd3;
    localparam logic [2:0] ST_NO_SLOT    = 3'd4;
    localparam logic [2:0] ST_OVERDUE    = 3'd5;
    localparam logic [2:0] ST_ZERO_RETRY = 3'd6;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    // Retry state that makes a release count into the histogram.
    localparam logic [1:0] RSTATE_COUNTED = 2'd1;

    typedef struct packed {
        logic        action;
        logic [3:0]  source;
        logic [31:0] message_number;
        logic [1:0]  retry_flag;
        logic [7:0]  flit_count;
        logic        is_data;
        logic [15:0] retry_count;
        logic [31:0] cycle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [4:0]  packets_held;
        logic [11:0] flits_held;
        logic [2:0]  retry_bin;
        logic [4:0]  max_packets_seen;
        logic [11:0] max_flits_seen;
        logic [15:0] max_retry_seen;
    } t_out_item;

    // One slot of a source table as kept in the slot memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [1:0]  retry_state;
        logic [7:0]  flits;
        logic        kind;
        logic [15:0] retries;
        logic [31:0] stamp;
    } t_slot_entry;

endpackage

`default_nettype wire

// ===== rtl/retransmit_buffer_table_unit.sv =====
// Retransmission buffer table: one table of packets per source node.
// Input channel (i_in_valid / o_in_stall) carries one transaction per
// operation: an add of a new packet, a refresh of a retried packet, or a
// free. Output channel (o_out_valid / i_out_stall) returns exactly one
// result transaction per input transaction, in order. The configuration
// channel (i_cfg_valid / o_cfg_ready) writes slots_in_use and is always ready.
// A transaction checks at most the active slot limit of its source's slots
// before its result is loaded. A single comparator walks the source's slots
// one per cycle through the slot memory's read port; that walk sets the rate,
// as the next transaction is taken only after the result is loaded.
// Only one transaction is in flight; o_in_stall is high while it is worked.
// A finished result sits in an output register, so the next transaction may
// be accepted while the receiver stalls; the one after that waits until the
// register is free. A stalled result holds its value.
// After reset the block sweeps the slot memory and occupancy memory, one
// entry per cycle, through all NUM_SOURCES * NUM_SLOTS slot addresses, and
// accepts no transaction until the sweep ends.
`default_nettype none

module retransmit_buffer_table_unit #(
    parameter int NUM_SOURCES = rbt_pkg::NUM_SOURCES_DEF,
    parameter int NUM_SLOTS   = rbt_pkg::NUM_SLOTS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rbt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rbt_pkg::t_out_item  o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [4:0]          i_cfg_data
);

    localparam int TOTAL  = NUM_SOURCES * NUM_SLOTS;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LIM_W  = $clog2(NUM_SLOTS + 1);
    localparam int PKT_W  = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [4:0]            r_slots_in_use;

    rbt_pkg::t_in_item     r_in;
    logic                  r_src_ok;
    logic [SRC_W-1:0]      r_src_idx;
    logic                  r_want_free;
    logic [LIM_W-1:0]      r_limit;
    logic [LIM_W-1:0]      r_idx;
    logic                  r_chk_valid;
    logic [SLOT_W-1:0]     r_chk_idx;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_slot;

    logic                  r_out_valid;
    rbt_pkg::t_out_item    r_out;

    logic [PKT_W-1:0]      r_peak_packets;
    logic [11:0]           r_peak_flits;
    logic [15:0]           r_peak_retries;
    logic [31:0]           r_hist [rbt_pkg::HIST_N];

    // Slot memory and per-source occupancy memory.
    rbt_pkg::t_slot_entry  r_slot_mem [TOTAL];
    rbt_pkg::t_slot_entry  r_rd_entry;
    logic [PKT_W-1:0]      r_occ_pkts_mem [NUM_SOURCES];
    logic [11:0]           r_occ_flits_mem [NUM_SOURCES];
    logic [PKT_W-1:0]      r_occ_pkts;
    logic [11:0]           r_occ_flits;

    logic                  in_accept;
    logic                  in_src_ok;
    logic [SRC_W-1:0]      in_src_idx;
    logic                  out_free;
    logic                  apply_go;
    logic                  match;
    logic                  scan_issue;
    logic [ADDR_W-1:0]     rd_addr;

    logic                  slot_we;
    logic [ADDR_W-1:0]     slot_waddr;
    rbt_pkg::t_slot_entry  slot_wdata;
    logic                  occ_we;
    logic [SRC_W-1:0]      occ_waddr;
    logic [PKT_W-1:0]      occ_wpkts;
    logic [11:0]           occ_wflits;

    // Result of the apply step.
    logic [2:0]            n_status;
    logic [2:0]            n_bin;
    logic [PKT_W-1:0]      n_pkts;
    logic [11:0]           n_flits;
    logic [PKT_W-1:0]      n_peak_packets;
    logic [11:0]           n_peak_flits;
    logic [15:0]           n_peak_retries;
    logic                  n_hist_inc;
    logic [3:0]            n_hist_idx;
    logic                  n_slot_we;
    logic                  n_occ_we;
    rbt_pkg::t_slot_entry  n_entry;
    logic [12:0]           flit_sum;
    logic [2:0]            bin_off;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_src_ok  = (int'(i_in_data.source) < NUM_SOURCES);
    assign in_src_idx = in_src_ok ? SRC_W'(i_in_data.source) : '0;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign apply_go   = (r_state == S_APPLY) && out_free;

    // The shared comparator: one slot is checked each cycle during the walk.
    assign match = r_chk_valid &&
                   (r_want_free ? !r_rd_entry.valid
                                : (r_rd_entry.valid &&
                                   r_rd_entry.tag == r_in.message_number));
    assign scan_issue = (r_state == S_SCAN) && !match && (r_idx < r_limit);
    assign rd_addr = ADDR_W'(int'(r_src_idx) * NUM_SLOTS + int'(r_idx));

    always_comb begin
        n_status       = rbt_pkg::ST_NO_SLOT;
        n_bin          = 3'd0;
        n_pkts         = r_occ_pkts;
        n_flits        = r_occ_flits;
        n_peak_packets = r_peak_packets;
        n_peak_flits   = r_peak_flits;
        n_peak_retries = r_peak_retries;
        n_hist_inc     = 1'b0;
        n_hist_idx     = 4'd0;
        n_slot_we      = 1'b0;
        n_occ_we       = 1'b0;
        n_entry        = r_rd_entry;
        flit_sum       = {1'b0, r_occ_flits} + {5'd0, r_in.flit_count};
        bin_off        = (r_rd_entry.retries > 16'(rbt_pkg::BIN_LIMIT))
                         ? 3'(rbt_pkg::BIN_LIMIT) : 3'(r_rd_entry.retries - 16'd1);

        if (!r_src_ok) begin
            n_status = (r_in.action == rbt_pkg::ACT_FREE) ? rbt_pkg::ST_FREE_MISS
                                                          : rbt_pkg::ST_NO_SLOT;
        end else if (r_in.action == rbt_pkg::ACT_ADD && r_in.retry_flag != 2'd0) begin
            if (r_found) begin
                n_status            = rbt_pkg::ST_REFRESHED;
                n_entry.retry_state = r_in.retry_flag;
                n_entry.stamp       = r_in.cycle;
                n_slot_we           = 1'b1;
            end
        end else if (r_in.action == rbt_pkg::ACT_ADD) begin
            if (r_found) begin
                n_status            = rbt_pkg::ST_INSERTED;
                n_entry.valid       = 1'b1;
                n_entry.tag         = r_in.message_number;
                n_entry.retry_state = 2'd0;
                n_entry.flits       = r_in.flit_count;
                n_entry.kind        = r_in.is_data;
                n_entry.retries     = r_in.retry_count;
                n_entry.stamp       = r_in.cycle;
                n_slot_we           = 1'b1;
                n_occ_we            = 1'b1;
                n_pkts              = r_occ_pkts + PKT_W'(1);
                n_flits             = flit_sum[12] ? rbt_pkg::FLIT_MAX : flit_sum[11:0];
                if (r_peak_packets < n_pkts) begin
                    n_peak_packets = n_pkts;
                end
                if (r_peak_flits < n_flits) begin
                    n_peak_flits = n_flits;
                end
            end
        end else begin
            if (!r_found) begin
                n_status = rbt_pkg::ST_FREE_MISS;
            end else if (r_rd_entry.stamp < r_in.cycle) begin
                n_status = rbt_pkg::ST_OVERDUE;
            end else if (r_rd_entry.retry_state == rbt_pkg::RSTATE_COUNTED &&
                         r_rd_entry.retries == 16'd0) begin
                n_status = rbt_pkg::ST_ZERO_RETRY;
            end else begin
                n_status      = rbt_pkg::ST_FREED;
                n_entry.valid = 1'b0;
                n_slot_we     = 1'b1;
                n_occ_we      = 1'b1;
                n_flits       = (r_occ_flits >= {4'd0, r_rd_entry.flits})
                                ? r_occ_flits - {4'd0, r_rd_entry.flits} : 12'd0;
                if (r_occ_pkts != '0) begin
                    n_pkts = r_occ_pkts - PKT_W'(1);
                end
                if (r_rd_entry.retry_state == rbt_pkg::RSTATE_COUNTED) begin
                    n_hist_inc = 1'b1;
                    n_hist_idx = (r_rd_entry.kind ? 4'd0 : 4'(rbt_pkg::BIN_LIMIT + 1))
                                 + {1'b0, bin_off};
                    n_bin      = bin_off + 3'd1;
                    if (r_peak_retries < r_rd_entry.retries) begin
                        n_peak_retries = r_rd_entry.retries;
                    end
                end
            end
        end
    end

    // Write port selection: the reset sweep, or the apply step.
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = rd_addr;
        slot_wdata = n_entry;
        occ_we     = 1'b0;
        occ_waddr  = r_src_idx;
        occ_wpkts  = n_pkts;
        occ_wflits = n_flits;
        if (r_state == S_CLEAR) begin
            slot_we    = 1'b1;
            slot_waddr = r_clr_addr;
            slot_wdata = '0;
            occ_we     = (int'(r_clr_addr) < NUM_SOURCES);
            occ_waddr  = SRC_W'(r_clr_addr);
            occ_wpkts  = '0;
            occ_wflits = '0;
        end else if (apply_go) begin
            slot_we    = n_slot_we;
            slot_waddr = ADDR_W'(int'(r_src_idx) * NUM_SLOTS + int'(r_slot));
            occ_we     = n_occ_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (scan_issue) begin
            r_rd_entry <= r_slot_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_pkts_mem[occ_waddr]  <= occ_wpkts;
            r_occ_flits_mem[occ_waddr] <= occ_wflits;
        end
        if (in_accept) begin
            r_occ_pkts  <= r_occ_pkts_mem[in_src_idx];
            r_occ_flits <= r_occ_flits_mem[in_src_idx];
        end
    end

    // Sequencer, configuration, high-water marks, histogram and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_slots_in_use <= rbt_pkg::SLOTS_IN_USE_RST;
            r_out_valid    <= 1'b0;
            r_chk_valid    <= 1'b0;
            r_peak_packets <= '0;
            r_peak_flits   <= '0;
            r_peak_retries <= '0;
            for (int i = 0; i < rbt_pkg::HIST_N; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_slots_in_use <= i_cfg_data;
            end
            // A result taken this cycle clears the register unless the apply
            // step reloads it at the same edge.
            if (r_out_valid && !i_out_stall && !apply_go) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (int'(r_clr_addr) == TOTAL - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_in        <= i_in_data;
                        r_src_ok    <= in_src_ok;
                        r_src_idx   <= in_src_idx;
                        r_want_free <= (i_in_data.action == rbt_pkg::ACT_ADD) &&
                                       (i_in_data.retry_flag == 2'd0);
                        if (!in_src_ok) begin
                            r_limit <= '0;
                        end else if (int'(r_slots_in_use) < NUM_SLOTS) begin
                            r_limit <= LIM_W'(r_slots_in_use);
                        end else begin
                            r_limit <= LIM_W'(NUM_SLOTS);
                        end
                        r_idx       <= '0;
                        r_chk_valid <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_slot  <= r_chk_idx;
                        r_state <= S_APPLY;
                    end else if (r_idx < r_limit) begin
                        r_chk_valid <= 1'b1;
                        r_chk_idx   <= r_idx[SLOT_W-1:0];
                        r_idx       <= r_idx + LIM_W'(1);
                    end else begin
                        r_found <= 1'b0;
                        r_slot  <= '0;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_out_valid             <= 1'b1;
                        r_out.status            <= n_status;
                        r_out.slot              <= r_found ? 4'(r_slot) : 4'd0;
                        r_out.packets_held      <= r_src_ok ? 5'(n_pkts) : 5'd0;
                        r_out.flits_held        <= r_src_ok ? n_flits : 12'd0;
                        r_out.retry_bin         <= n_bin;
                        r_out.max_packets_seen  <= 5'(n_peak_packets);
                        r_out.max_flits_seen    <= n_peak_flits;
                        r_out.max_retry_seen    <= n_peak_retries;
                        r_peak_packets          <= n_peak_packets;
                        r_peak_flits            <= n_peak_flits;
                        r_peak_retries          <= n_peak_retries;
                        if (n_hist_inc) begin
                            r_hist[n_hist_idx] <= r_hist[n_hist_idx] + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result only appears right after the apply step.
    a_out_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_APPLY)
        else $error("result register loaded outside the apply step");

    // An accepted transaction always starts a slot walk.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_SCAN)
        else $error("accepted transaction did not start a slot walk");

    // The walk never runs past the active slot limit.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_idx <= r_limit)
        else $error("slot walk ran past the slot limit");

    // Nothing is written back unless the apply step fires or the sweep runs.
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |-> (r_state == S_CLEAR || apply_go))
        else $error("slot memory written outside sweep or apply step");

endmodule

`default_nettype wire
